// ----- rtl/hsl_pkg.sv -----
// Shared types, constants and the ramp weight function of the HSL to RGB pipeline.
package hsl_pkg;

    localparam int unsigned NCH       = 3;
    localparam int unsigned CH_RED    = 0;
    localparam int unsigned CH_GREEN  = 1;
    localparam int unsigned CH_BLUE   = 2;

    localparam int unsigned HUE_SHIFT = 16;
    localparam logic [15:0] HUE_RECIP =
        16'(((64'd256 << HUE_SHIFT) + 64'd359) / 64'd360);

    localparam int unsigned RND_SHIFT = 39;
    localparam logic [23:0] RND_RECIP =
        24'(((64'd1 << RND_SHIFT) + 64'd43349) / 64'd43350);
    localparam logic [14:0] RND_BIAS  = 15'd21675;

    localparam logic signed [10:0] HUE_OFS  = 11'sd85;
    localparam logic signed [10:0] HUE_WRAP = 11'sd255;

    typedef struct packed {
        logic        grey;
        logic [7:0]  light;
        logic [8:0]  hue;
        logic [15:0] hi;
    } t_lvl;

    typedef struct packed {
        logic                grey;
        logic [7:0]          light;
        logic [15:0]         lo;
        logic [15:0]         diff;
        logic [NCH-1:0][6:0] wgt;
    } t_ramp;

    typedef struct packed {
        logic                 grey;
        logic [7:0]           light;
        logic [NCH-1:0][23:0] num;
    } t_mix;

    typedef struct packed {
        logic [NCH-1:0][7:0] chan;
    } t_rgb;

    function automatic logic [6:0] ramp_wgt(input logic signed [10:0] pos);
        logic signed [10:0] p;
        logic [7:0]         x;
        logic [7:0]         t;
        logic [6:0]         w;
        p = pos;
        if (p > HUE_WRAP) begin
            p = p - HUE_WRAP;
        end else if (p < 11'sd0) begin
            p = p + HUE_WRAP;
        end
        x = p[7:0];
        t = 8'd170 - x;
        if (x <= 8'd42) begin
            w = {x[5:0], 1'b0};
        end else if (x <= 8'd127) begin
            w = 7'd85;
        end else if (x < 8'd170) begin
            w = {t[5:0], 1'b0};
        end else begin
            w = 7'd0;
        end
        return w;
    endfunction

endpackage

// ----- rtl/hsl_to_rgb_pixel_top.sv -----
// Top level of the HSL to RGB pixel converter: four-stage pipeline.
// An accepted request passes the stage registers of lvl, ramp, mix and rnd in order before o_valid rises.
// Throughput: one pixel per cycle while no stall holds the pipeline; each stage holds one pixel.
// Stall ripples back through the per-stage ready logic; a full pipeline stalls the input while i_stall is high.
// Reset (synchronous, active low) clears the stage valid bits only.
module hsl_to_rgb_pixel_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [8:0] i_hue_deg,
    input  logic [7:0] i_sat,
    input  logic [7:0] i_light,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_red,
    output logic [7:0] o_green,
    output logic [7:0] o_blue
);
    import hsl_pkg::*;

    logic  v1;
    logic  v2;
    logic  v3;
    logic  s2;
    logic  s3;
    logic  s4;
    t_lvl  d1;
    t_ramp d2;
    t_mix  d3;
    t_rgb  d4;

    hsl_lvl u_lvl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_hue_deg (i_hue_deg),
        .i_sat     (i_sat),
        .i_light   (i_light),
        .o_stall   (o_stall),
        .o_valid   (v1),
        .o_data    (d1),
        .i_stall   (s2)
    );

    hsl_ramp u_ramp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (v1),
        .i_data  (d1),
        .o_stall (s2),
        .o_valid (v2),
        .o_data  (d2),
        .i_stall (s3)
    );

    hsl_mix u_mix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (v2),
        .i_data  (d2),
        .o_stall (s3),
        .o_valid (v3),
        .o_data  (d3),
        .i_stall (s4)
    );

    hsl_rnd u_rnd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (v3),
        .i_data  (d3),
        .o_stall (s4),
        .o_valid (o_valid),
        .o_data  (d4),
        .i_stall (i_stall)
    );

    assign o_red   = d4.chan[CH_RED];
    assign o_green = d4.chan[CH_GREEN];
    assign o_blue  = d4.chan[CH_BLUE];

`ifndef SYNTHESIS
    a_empty_no_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!v1 && !v2 && !v3 && !o_valid) |-> !o_stall)
        else $error("input stalled with empty pipeline");

    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (v1 && v2 && v3 && o_valid && i_stall) |-> o_stall)
        else $error("full stalled pipeline took a request");

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) ##1 !i_stall ##1 !i_stall ##1 !i_stall |=> o_valid)
        else $error("request did not reach the output in four cycles");

    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && !v3) |=> !o_valid)
        else $error("output valid without a pixel behind it");
`endif

endmodule

// ----- rtl/hsl_lvl.sv -----
// Stage one: hue scaling to the 256 circle and the upper mixing level.
module hsl_lvl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic [8:0]    i_hue_deg,
    input  logic [7:0]    i_sat,
    input  logic [7:0]    i_light,
    output logic          o_stall,
    output logic          o_valid,
    output hsl_pkg::t_lvl o_data,
    input  logic          i_stall
);
    import hsl_pkg::*;

    logic        r_valid;
    t_lvl        r_data;
    t_lvl        n_data;
    logic        adv;
    logic [24:0] hue_prod;
    logic [16:0] hi_low;
    logic [16:0] hi_high;

    assign adv     = !r_valid || !i_stall;
    assign o_stall = !adv;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_comb begin
        hue_prod     = 25'(i_hue_deg) * 25'(HUE_RECIP);
        hi_low       = 17'(i_light) * (17'd255 + 17'(i_sat));
        hi_high      = 17'd255 * (17'(i_light) + 17'(i_sat)) - 17'(i_light) * 17'(i_sat);
        n_data.grey  = (i_sat == 8'd0);
        n_data.light = i_light;
        n_data.hue   = hue_prod[HUE_SHIFT+8:HUE_SHIFT];
        n_data.hi    = i_light[7] ? hi_high[15:0] : hi_low[15:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && i_valid) begin
            r_data <= n_data;
        end
    end

endmodule

// ----- rtl/hsl_ramp.sv -----
// Stage two: lower mixing level, level span and the per-channel ramp weights.
module hsl_ramp (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  hsl_pkg::t_lvl  i_data,
    output logic           o_stall,
    output logic           o_valid,
    output hsl_pkg::t_ramp o_data,
    input  logic           i_stall
);
    import hsl_pkg::*;

    logic               r_valid;
    t_ramp              r_data;
    t_ramp              n_data;
    logic               adv;
    logic [16:0]        lo_full;
    logic signed [10:0] hue_s;

    assign adv     = !r_valid || !i_stall;
    assign o_stall = !adv;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_comb begin
        lo_full                = 17'd510 * 17'(i_data.light) - 17'(i_data.hi);
        hue_s                  = $signed({2'b00, i_data.hue});
        n_data.grey            = i_data.grey;
        n_data.light           = i_data.light;
        n_data.lo              = lo_full[15:0];
        n_data.diff            = i_data.hi - lo_full[15:0];
        n_data.wgt[CH_RED]     = ramp_wgt(hue_s + HUE_OFS);
        n_data.wgt[CH_GREEN]   = ramp_wgt(hue_s);
        n_data.wgt[CH_BLUE]    = ramp_wgt(hue_s - HUE_OFS);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && i_valid) begin
            r_data <= n_data;
        end
    end

endmodule

// ----- rtl/hsl_mix.sv -----
// Stage three: weighted mix of the two levels with the rounding bias.
module hsl_mix (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  hsl_pkg::t_ramp i_data,
    output logic           o_stall,
    output logic           o_valid,
    output hsl_pkg::t_mix  o_data,
    input  logic           i_stall
);
    import hsl_pkg::*;

    logic               r_valid;
    t_mix               r_data;
    t_mix               n_data;
    logic               adv;
    logic [NCH-1:0][24:0] mix;

    assign adv     = !r_valid || !i_stall;
    assign o_stall = !adv;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_comb begin
        n_data.grey  = i_data.grey;
        n_data.light = i_data.light;
        for (int c = 0; c < NCH; c++) begin
            mix[c] = ((25'd85 * 25'(i_data.lo) + 25'(i_data.wgt[c]) * 25'(i_data.diff)) << 1)
                     + 25'(RND_BIAS);
            n_data.num[c] = mix[c][23:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && i_valid) begin
            r_data <= n_data;
        end
    end

endmodule

// ----- rtl/hsl_rnd.sv -----
// Stage four: reciprocal divide to 8-bit channels, grey select, output register.
module hsl_rnd (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  hsl_pkg::t_mix i_data,
    output logic          o_stall,
    output logic          o_valid,
    output hsl_pkg::t_rgb o_data,
    input  logic          i_stall
);
    import hsl_pkg::*;

    logic                 r_valid;
    t_rgb                 r_data;
    t_rgb                 n_data;
    logic                 adv;
    logic [NCH-1:0][47:0] prod;

    assign adv     = !r_valid || !i_stall;
    assign o_stall = !adv;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_comb begin
        for (int c = 0; c < NCH; c++) begin
            prod[c] = 48'(i_data.num[c]) * 48'(RND_RECIP);
            n_data.chan[c] = i_data.grey ? i_data.light : prod[c][RND_SHIFT+7:RND_SHIFT];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && i_valid) begin
            r_data <= n_data;
        end
    end

endmodule

// ----- test/hsl_to_rgb_pixel_top_test.sv -----
// Self-checking testbench of the HSL to RGB pixel converter with a prediction scoreboard.
`timescale 1ns / 1ps

module hsl_to_rgb_pixel_top_test;

    typedef struct packed {
        bit [7:0] red;
        bit [7:0] green;
        bit [7:0] blue;
    } t_rgb;

    class pixel_scoreboard;
        t_rgb        pending_rgb[$];
        int unsigned n_requests;
        int unsigned n_grey;
        int unsigned n_wide_hue;
        int unsigned n_checked;
        int unsigned n_errors;

        function bit [7:0] ramp_level(int unsigned lo, int unsigned hi, int pos);
            int unsigned w;
            int unsigned n;
            if (pos > 255) begin
                pos -= 255;
            end else if (pos < 0) begin
                pos += 255;
            end
            if (pos <= 42) begin
                w = 2 * pos;
            end else if (pos <= 127) begin
                w = 85;
            end else if (pos < 170) begin
                w = 2 * (170 - pos);
            end else begin
                w = 0;
            end
            n = 85 * lo + w * (hi - lo);
            return 8'((2 * n + 21675) / 43350);
        endfunction

        function t_rgb pixel_rgb(bit [8:0] hue_deg, bit [7:0] sat, bit [7:0] light);
            t_rgb        px;
            int          h;
            int unsigned hi;
            int unsigned lo;
            if (sat == 0) begin
                px = '{light, light, light};
                return px;
            end
            h = (int'(hue_deg) * 256) / 360;
            if (light < 128) begin
                hi = light * (255 + sat);
            end else begin
                hi = 255 * (light + sat) - light * sat;
            end
            lo = 510 * light - hi;
            px.red   = ramp_level(lo, hi, h + 85);
            px.green = ramp_level(lo, hi, h);
            px.blue  = ramp_level(lo, hi, h - 85);
            return px;
        endfunction

        function void note_request(bit [8:0] hue_deg, bit [7:0] sat, bit [7:0] light);
            n_requests++;
            if (sat == 0) n_grey++;
            if (hue_deg > 360) n_wide_hue++;
            pending_rgb.push_back(pixel_rgb(hue_deg, sat, light));
        endfunction

        function void check_field(string name, bit [7:0] exp_val, logic [7:0] act_val);
            if (exp_val !== act_val) begin
                n_errors++;
                $error("%s: expected %0d, got %0d", name, exp_val, act_val);
            end
        endfunction

        function void check_result(logic [7:0] red, logic [7:0] green, logic [7:0] blue);
            t_rgb px;
            if (pending_rgb.size() == 0) begin
                n_errors++;
                $error("pixel %0d/%0d/%0d arrived with no request pending", red, green, blue);
                return;
            end
            px = pending_rgb.pop_front();
            n_checked++;
            check_field("red", px.red, red);
            check_field("green", px.green, green);
            check_field("blue", px.blue, blue);
        endfunction

        function int unsigned pending();
            return pending_rgb.size();
        endfunction
    endclass

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic [8:0] i_hue_deg = '0;
    logic [7:0] i_sat = '0;
    logic [7:0] i_light = '0;
    logic       i_stall = 1'b0;
    logic       o_stall;
    logic       o_valid;
    logic [7:0] o_red;
    logic [7:0] o_green;
    logic [7:0] o_blue;

    pixel_scoreboard sb = new();
    bit              no_idle = 1'b0;
    bit              rx_long_hold = 1'b0;
    bit              rx_hold_taken = 1'b0;

    hsl_to_rgb_pixel_top dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_hue_deg (i_hue_deg),
        .i_sat     (i_sat),
        .i_light   (i_light),
        .o_valid   (o_valid),
        .i_stall   (i_stall),
        .o_red     (o_red),
        .o_green   (o_green),
        .o_blue    (o_blue)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && !o_stall) sb.note_request(i_hue_deg, i_sat, i_light);
        if (i_rst_n && o_valid && !i_stall) sb.check_result(o_red, o_green, o_blue);
    end

    function automatic int unsigned idle_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    task automatic send_pixel(input bit [8:0] hue, input bit [7:0] sat, input bit [7:0] light);
        int unsigned gap;
        gap = no_idle ? 0 : idle_len();
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_hue_deg <= hue;
        i_sat     <= sat;
        i_light   <= light;
        @(negedge i_clk);
        while (o_stall) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic send_random_pixel();
        bit [8:0]    hue;
        bit [7:0]    sat;
        bit [7:0]    light;
        int unsigned r;
        r   = $urandom_range(0, 99);
        hue = (r < 85) ? 9'($urandom_range(0, 360)) : 9'($urandom_range(361, 511));
        r   = $urandom_range(0, 99);
        sat = (r < 10) ? 8'd0 : (r < 15) ? 8'd255 : 8'($urandom_range(1, 255));
        r   = $urandom_range(0, 99);
        light = (r < 5) ? 8'd0 : (r < 10) ? 8'd255 : 8'($urandom_range(0, 255));
        send_pixel(hue, sat, light);
    endtask

    task automatic wait_all_results();
        do @(posedge i_clk); while (sb.pending() != 0);
    endtask

    initial begin
        int unsigned stall_len;
        int unsigned run_len;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            if (rx_long_hold && !rx_hold_taken) begin
                rx_hold_taken = 1'b1;
                stall_len = 400;
            end else begin
                stall_len = no_idle ? 0 : idle_len();
            end
            run_len = $urandom_range(1, 12);
            if (stall_len != 0) begin
                i_stall <= 1'b1;
                repeat (stall_len) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            repeat (run_len) @(posedge i_clk);
        end
    end

    initial begin
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        int          dir_pix [22][3] = '{
            '{0, 0, 0},     '{360, 0, 255},   '{511, 0, 128},   '{0, 255, 255},
            '{0, 255, 0},   '{0, 255, 127},   '{0, 255, 128},   '{120, 255, 128},
            '{240, 255, 128}, '{360, 255, 128}, '{361, 200, 100}, '{511, 255, 255},
            '{511, 1, 1},   '{359, 128, 200}, '{241, 255, 128}, '{60, 255, 64},
            '{180, 90, 200}, '{300, 1, 254},  '{85, 255, 128},  '{255, 170, 127},
            '{256, 77, 33}, '{100, 255, 1}
        };
        int unsigned drain;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_pix[k]) begin
            send_pixel(9'(dir_pix[k][0]), 8'(dir_pix[k][1]), 8'(dir_pix[k][2]));
        end
        repeat (300) send_random_pixel();

        i_valid <= 1'b0;
        wait_all_results();
        @(posedge i_clk);

        rx_long_hold = 1'b1;
        wait (rx_hold_taken);
        no_idle = 1'b1;
        repeat (40) send_random_pixel();
        repeat (200) send_random_pixel();
        no_idle = 1'b0;
        repeat (190) send_random_pixel();
        i_valid <= 1'b0;

        drain = 0;
        do begin
            @(posedge i_clk);
            drain++;
        end while (sb.pending() != 0 && drain < 20000);
        if (sb.pending() != 0) begin
            sb.n_errors++;
            $error("%0d expected pixels never arrived", sb.pending());
        end
        repeat (8) @(posedge i_clk);

        $display("Converted %0d pixels (%0d grey, %0d with hue above 360), checked %0d.",
                 sb.n_requests, sb.n_grey, sb.n_wide_hue, sb.n_checked);
        $display("Random gaps and stalls on both sides, one long output hold-off.");
        if (sb.n_errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ----- files.f -----
rtl/hsl_pkg.sv
rtl/hsl_lvl.sv
rtl/hsl_ramp.sv
rtl/hsl_mix.sv
rtl/hsl_rnd.sv
rtl/hsl_to_rgb_pixel_top.sv
test/hsl_to_rgb_pixel_top_test.sv
